[hw/rtl/kdst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kdst_pkg;

  localparam int STAT_W  = 32;
  localparam int KEY_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_CREATED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  source_key;
    logic [STAT_W-1:0] start_stamp;
    logic [STAT_W-1:0] end_stamp;
    logic [5:0]        read_slot;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [5:0]        slot;
    logic [KEY_W-1:0]  entry_key;
    logic [STAT_W-1:0] calls;
    logic [STAT_W-1:0] total_time;
    logic [STAT_W-1:0] min_time;
    logic [STAT_W-1:0] max_time;
    logic [6:0]        entries_used;
  } rsp_t;

  // classified operation handed from front to back
  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [STAT_W-1:0]  elapsed;
    logic [COUNT_W-1:0] used;
  } job_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [STAT_W-1:0] calls;
    logic [STAT_W-1:0] total;
    logic [STAT_W-1:0] min_t;
    logic [STAT_W-1:0] max_t;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/kdst_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module kdst_front import kdst_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req,
  output logic req_stall,
  input  logic q_full,
  output logic push,
  output job_t job
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic [KW-1:0]            keys [TABLE_ENTRIES];
  logic [CW-1:0]            used;
  logic [KW-1:0]            key;
  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic [IW-1:0]            hit_idx;
  logic                     full;
  logic                     rd_ok;
  logic                     create;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // key match across all occupied entries; keys are unique so at most one hits
  always_comb begin
    key     = req.source_key[KW-1:0];
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (CW'(i) < used) && (keys[i] == key);
      if (match[i]) hit_idx = hit_idx | IW'(i);
    end
    hit    = |match;
    full   = (used == CW'(TABLE_ENTRIES));
    rd_ok  = COUNT_W'(req.read_slot) < COUNT_W'(used);
    create = (req.action != ACT_READ) && !hit && !full;
  end

  always_comb begin
    job.elapsed = req.end_stamp - req.start_stamp;
    job.used    = COUNT_W'(used) + COUNT_W'(create);
    if (req.action == ACT_READ) begin
      job.status = rd_ok ? ST_READ_OK : ST_READ_EMPTY;
      job.slot   = SLOT_W'(req.read_slot);
      job.key    = '0;
    end else if (hit) begin
      job.status = ST_UPDATED;
      job.slot   = SLOT_W'(hit_idx);
      job.key    = KEY_W'(key);
    end else if (!full) begin
      job.status = ST_CREATED;
      job.slot   = SLOT_W'(used);
      job.key    = KEY_W'(key);
    end else begin
      job.status = ST_FULL;
      job.slot   = '0;
      job.key    = KEY_W'(key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (push && create) begin
      used <= used + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && create) begin
      keys[IW'(used)] <= key;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("duplicate key in table");

  assert property (@(posedge clk) disable iff (rst) used <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    !(push && create) |=> $stable(used))
    else $error("entry count changed without a new key");

`default_nettype wire
endmodule

[hw/rtl/kdst_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module kdst_queue import kdst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t       entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("pop from empty queue");

`default_nettype wire
endmodule

[hw/rtl/kdst_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module kdst_back import kdst_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic {
    BK_IDLE,
    BK_CALC
  } state_t;

  state_t state;
  job_t   cur;
  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;
  entry_t upd;
  logic   load;
  logic   wr_en;

  assign pop   = (state == BK_IDLE) && q_valid;
  assign load  = (state == BK_CALC) && (!rsp_valid || !rsp_stall);
  assign wr_en = load && (cur.status == ST_UPDATED || cur.status == ST_CREATED);

  always_comb begin
    upd     = '0;
    upd.key = cur.key;
    case (cur.status)
      ST_UPDATED: begin
        upd.key   = rdata.key;
        upd.calls = rdata.calls + STAT_W'(1);
        upd.total = rdata.total + cur.elapsed;
        upd.min_t = (cur.elapsed < rdata.min_t) ? cur.elapsed : rdata.min_t;
        upd.max_t = (cur.elapsed > rdata.max_t) ? cur.elapsed : rdata.max_t;
      end
      ST_CREATED: begin
        upd.calls = STAT_W'(1);
        upd.total = cur.elapsed;
        upd.min_t = cur.elapsed;
        upd.max_t = cur.elapsed;
      end
      ST_READ_OK: begin
        upd = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(cur.slot)] <= upd;
    end
    if (pop && (q_job.status == ST_UPDATED || q_job.status == ST_READ_OK)) begin
      rdata <= mem[IW'(q_job.slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop) begin
            cur   <= q_job;
            state <= BK_CALC;
          end
        end
        BK_CALC: begin
          if (load) state <= BK_IDLE;
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
      if (load) begin
        rsp_valid        <= 1'b1;
        rsp.status       <= cur.status;
        rsp.slot         <= 6'(cur.slot);
        rsp.entry_key    <= upd.key;
        rsp.calls        <= upd.calls;
        rsp.total_time   <= upd.total;
        rsp.min_time     <= upd.min_t;
        rsp.max_time     <= upd.max_t;
        rsp.entries_used <= 7'(cur.used);
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`default_nettype wire
endmodule

[hw/rtl/keyed_duration_stats_table.sv]
// Profiling statistics table keyed by a source id.
// Request channel (req_valid / req_stall / req): action 0 records one duration
// (end_stamp - start_stamp, mod 2^32) for source_key, creating an entry if the
// key is new and the table is not full; action 1 reads the entry at read_slot.
// A word moves on an edge with valid high and stall low.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per
// request, in request order, giving status, slot, key, statistics and the
// number of occupied entries.
// A request passes through the two-word queue, the back-end job register and
// the response register. The back end handles one request at a time, a
// read-modify-write of the statistics memory (one read port, one write port).
// Key lookup is a parallel compare across all entries in the accepting cycle.
// Reset: table empty, queue empty, rsp_valid low; no clearing pass.
// Response stall: the response word holds; requests keep being taken into a
// two-word queue, after which req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module keyed_duration_stats_table import kdst_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t push_job;
  job_t head;

  kdst_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BITS     (KEY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .req_stall(req_stall),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  kdst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .head    (head)
  );

  kdst_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (head),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

`default_nettype wire
endmodule
